// ----- design/omsm_pkg.sv -----
// shared types and constants for the omega statistic block
// no dependencies
package omsm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EPS_W         = 16;
    localparam int IN_DATA_W     = 96;
    localparam int OUT_DATA_W    = 64;
    localparam int SUM_W         = 25;
    localparam int NUM_W         = 41;
    localparam int DEN_W         = 49;
    localparam int Q_W           = 32;
    localparam int MAX_W         = 31;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             divz;
        logic             neg;
    } prep_t;

    typedef struct packed {
        logic [Q_W-1:0]   omega;
        logic [MAX_W-1:0] pos_val;
        logic             positive;
        logic             sat;
    } res_t;

endpackage

// ----- design/omsm_prep.sv -----
// operand preparation: sums, site products, signed denominator, numerator
// depends on omsm_pkg
module omsm_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [7:0]            left_sites,
    input  logic [7:0]            right_sites,
    input  logic [23:0]           left_sum,
    input  logic [23:0]           right_sum,
    input  logic [31:0]           cross_sum,
    input  logic [15:0]           epsilon,
    output logic                  prep_valid,
    output omsm_pkg::prep_t       prep
);
    import omsm_pkg::*;

    logic [3:0]       vld_reg;
    logic [SUM_W-1:0] s1_reg, s2_reg;
    logic [15:0]      mm1_reg, nn1_reg, mn1_reg;
    logic [31:0]      c1_reg, c2_reg;
    logic [15:0]      p2_reg, p3_reg;
    logic [31:0]      emn2_reg;
    logic [NUM_W-1:0] num2_reg, num3_reg;
    logic             mnz2_reg, mnz3_reg;
    logic [33:0]      d3_reg;
    logic [32:0]      absd;
    prep_t            out_reg;

    assign absd = d3_reg[33] ? 33'(~d3_reg + 34'd1) : d3_reg[32:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg   <= {1'b0, left_sum} + {1'b0, right_sum};
        mm1_reg  <= {8'd0, left_sites} * ({8'd0, left_sites} - 16'd1);
        nn1_reg  <= {8'd0, right_sites} * ({8'd0, right_sites} - 16'd1);
        mn1_reg  <= {8'd0, left_sites} * {8'd0, right_sites};
        c1_reg   <= cross_sum;

        p2_reg   <= {1'b0, mm1_reg[15:1]} + {1'b0, nn1_reg[15:1]};
        emn2_reg <= {16'd0, epsilon} * {16'd0, mn1_reg};
        num2_reg <= NUM_W'(s1_reg) * NUM_W'(mn1_reg);
        mnz2_reg <= (mn1_reg == 16'd0);
        s2_reg   <= s1_reg;
        c2_reg   <= c1_reg;

        d3_reg   <= {2'b00, c2_reg} + {2'b00, emn2_reg} - {9'd0, s2_reg};
        p3_reg   <= p2_reg;
        num3_reg <= num2_reg;
        mnz3_reg <= mnz2_reg;

        out_reg.num  <= num3_reg;
        out_reg.den  <= DEN_W'(p3_reg) * DEN_W'(absd);
        out_reg.neg  <= d3_reg[33];
        out_reg.divz <= (p3_reg == 16'd0) | mnz3_reg | (d3_reg == 34'd0);
    end

    assign prep_valid = vld_reg[3];
    assign prep       = out_reg;

endmodule

// ----- design/omsm_div.sv -----
// bit-serial restoring divider with saturation and sign handling
// depends on omsm_pkg
module omsm_div #(
    parameter int FRAC_BITS = omsm_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  omsm_pkg::prep_t prep,
    output logic            done,
    output omsm_pkg::res_t  res
);
    import omsm_pkg::*;

    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int R_W   = DEN_W + 1;
    localparam logic [4:0] CNT_MAX = 5'(Q_W - 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t          state_reg;
    logic             done_reg;
    res_t             res_reg;
    logic [R_W-1:0]   r_reg, r_next, rs, den_ext, hi_ext;
    logic [Q_W-1:0]   lo_reg, q_reg, mag, neg_omega, pos_omega;
    logic [DEN_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             big_reg, neg_reg, ge, pos_sat, neg_over;
    logic [DVD_W-1:0] dvd;

    assign dvd     = {prep.num, {FRAC_BITS{1'b0}}};
    assign hi_ext  = R_W'(dvd[DVD_W-1:Q_W]);
    assign den_ext = {1'b0, den_reg};
    assign rs      = {r_reg[R_W-2:0], lo_reg[Q_W-1]};
    assign ge      = (rs >= den_ext);
    assign r_next  = ge ? (rs - den_ext) : rs;

    assign pos_sat   = big_reg | q_reg[Q_W-1];
    assign pos_omega = pos_sat ? 32'h7FFF_FFFF : q_reg;
    assign neg_over  = big_reg | (q_reg[Q_W-1] & (|q_reg[Q_W-2:0]));
    assign mag       = neg_over ? 32'h8000_0000 : q_reg;
    assign neg_omega = (~mag) + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        if (prep.divz)
                        begin
                            res_reg.omega    <= 32'h7FFF_FFFF;
                            res_reg.pos_val  <= '1;
                            res_reg.positive <= 1'b1;
                            res_reg.sat      <= 1'b1;
                            done_reg         <= 1'b1;
                        end
                        else
                        begin
                            r_reg     <= hi_ext;
                            lo_reg    <= dvd[Q_W-1:0];
                            den_reg   <= prep.den;
                            big_reg   <= (hi_ext >= {1'b0, prep.den});
                            neg_reg   <= prep.neg;
                            cnt_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN:
                begin
                    r_reg   <= r_next;
                    lo_reg  <= {lo_reg[Q_W-2:0], 1'b0};
                    q_reg   <= {q_reg[Q_W-2:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CNT_MAX)
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    if (neg_reg)
                    begin
                        res_reg.omega    <= neg_omega;
                        res_reg.pos_val  <= '0;
                        res_reg.positive <= 1'b0;
                        res_reg.sat      <= neg_over;
                    end
                    else
                    begin
                        res_reg.omega    <= pos_omega;
                        res_reg.pos_val  <= pos_omega[MAX_W-1:0];
                        res_reg.positive <= 1'b1;
                        res_reg.sat      <= pos_sat;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- design/omega_statistic_max_top.sv -----
// throughput: one request at a time; a division by zero skips the 32-step
// bit-serial divider; the next request is taken once the result moves into the
// output register, even while that result waits
// reset: asynchronous active low, clears handshake state and running max,
// epsilon returns to round(0.01 * 2^FRAC_BITS)
module omega_statistic_max_top #(
    parameter int FRAC_BITS = omsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // left_sites, right_sites, left_sum, right_sum, cross_sum
    input  logic [omsm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // omega, running_max, saturated
    output logic [omsm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [omsm_pkg::EPS_W-1:0]      cfg_data
);
    import omsm_pkg::*;

    localparam int EPS_RAW = ((1 << FRAC_BITS) + 50) / 100;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(EPS_RAW > 65535 ? 65535 : EPS_RAW);

    logic [EPS_W-1:0] eps_reg;
    logic             busy_reg, pend_reg, last_reg;
    logic             ovalid_reg, olast_reg, osat_reg;
    logic [Q_W-1:0]   omega_reg;
    logic [MAX_W-1:0] rmax_reg, max_reg, new_max;
    logic             accept, prep_valid, div_done, load;
    prep_t            prep;
    res_t             res;

    assign accept        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = ~busy_reg;
    assign cfg_ready     = 1'b1;
    assign load          = pend_reg & (~ovalid_reg | m_axis_tready);
    assign new_max       = (res.positive && (res.pos_val > max_reg)) ? res.pos_val : max_reg;

    omsm_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .left_sites  (s_axis_tdata[7:0]),
        .right_sites (s_axis_tdata[15:8]),
        .left_sum    (s_axis_tdata[39:16]),
        .right_sum   (s_axis_tdata[63:40]),
        .cross_sum   (s_axis_tdata[95:64]),
        .epsilon     (eps_reg),
        .prep_valid  (prep_valid),
        .prep        (prep)
    );

    omsm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (prep_valid),
        .prep  (prep),
        .done  (div_done),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= EPS_RESET;
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            max_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                eps_reg <= cfg_data;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            if (div_done)
            begin
                pend_reg <= 1'b1;
            end
            if (load)
            begin
                pend_reg   <= 1'b0;
                busy_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
                max_reg    <= last_reg ? '0 : new_max;
            end
            else if (m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= s_axis_tlast;
        end
        if (load)
        begin
            omega_reg <= res.omega;
            rmax_reg  <= new_max;
            osat_reg  <= res.sat;
            olast_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {osat_reg, rmax_reg, omega_reg};
    assign m_axis_tlast  = olast_reg;

endmodule

// ----- design/omsm_check.sv -----
// port-level checks for the omega statistic block, bound to the top level
// depends on omsm_pkg
module omsm_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [omsm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);
    import omsm_pkg::*;

    logic [MAX_W-1:0] prev_max_reg;
    logic             fresh_reg;
    logic             out_acc;

    assign out_acc = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_max_reg <= '0;
            fresh_reg    <= 1'b1;
        end
        else if (out_acc)
        begin
            prev_max_reg <= m_axis_tdata[62:32];
            fresh_reg    <= m_axis_tlast;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !fresh_reg |-> m_axis_tdata[62:32] >= prev_max_reg)
        else $error("running max fell within a vector");

    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[31] |-> m_axis_tdata[62:32] >= m_axis_tdata[30:0])
        else $error("running max below omega");

    a_sat_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[63] && !m_axis_tdata[31]
        |-> m_axis_tdata[31:0] == 32'h7FFF_FFFF)
        else $error("positive saturation not clamped");

endmodule

bind omega_statistic_max_top omsm_check u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/omega_statistic_max_top_test.sv -----
// self-checking test of the omega statistic block: stream requests in, compare
// each result with a local predictor of omega, running max and saturation
// depends on design/omsm_pkg.sv and design/omega_statistic_max_top.sv
`timescale 1ns / 100ps
module omega_statistic_max_top_test;
    import omsm_pkg::*;

    typedef struct {
        logic [31:0] omega;
        logic [30:0] run_max;
        logic        sat;
        logic        last;
    } omega_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [EPS_W-1:0]      cfg_data = '0;

    omega_res_t  expected_q[$];
    logic [15:0] eps_reg = 16'd655;
    logic [30:0] vec_max = '0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          sat_seen = 0;
    int          neg_seen = 0;
    int          stall_cycles = 0;
    bit          quiet = 1'b0;
    bit          timed_out = 1'b0;

    omega_statistic_max_top dut (.*);

    always #4 clk = ~clk;

    function automatic logic [63:0] fx_quot(logic [63:0] num, logic [63:0] den,
                                            logic [63:0] limit, ref bit sat);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (q > limit)
        begin
            sat = 1'b1;
            return limit;
        end
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q[0] = 1'b1;
            end
            if (q > limit)
            begin
                sat = 1'b1;
                return limit;
            end
        end
        return q;
    endfunction

    function automatic omega_res_t predict_omega(logic [7:0] m, logic [7:0] n,
                                                 logic [23:0] ls, logic [23:0] rs,
                                                 logic [31:0] cs, logic last);
        omega_res_t  r;
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] mn;
        longint      d;
        bit          sat;
        bit          pos;
        logic [63:0] pv;
        logic [63:0] mag;
        s = ls + rs;
        p = (m * (m > 0 ? m - 1 : 0)) / 2 + (n * (n > 0 ? n - 1 : 0)) / 2;
        mn = m * n;
        d = longint'(cs) - longint'(s) + longint'(eps_reg * mn);
        sat = 1'b0;
        pos = 1'b0;
        pv = 0;
        if (p == 0 || mn == 0 || d == 0)
        begin
            sat = 1'b1;
            pos = 1'b1;
            pv = 64'h7FFFFFFF;
            r.omega = 32'h7FFFFFFF;
        end
        else if (s == 0)
            r.omega = '0;
        else if (d > 0)
        begin
            pv = fx_quot(s * mn, p * d, 64'h7FFFFFFF, sat);
            pos = 1'b1;
            r.omega = pv[31:0];
        end
        else
        begin
            mag = fx_quot(s * mn, p * (-d), 64'h80000000, sat);
            r.omega = 32'(-mag);
        end
        if (pos && pv > vec_max)
            vec_max = pv[30:0];
        r.run_max = vec_max;
        r.sat = sat;
        r.last = last;
        if (last)
            vec_max = '0;
        return r;
    endfunction

    task automatic send_split(logic [7:0] m, logic [7:0] n, logic [23:0] ls,
                              logic [23:0] rs, logic [31:0] cs, logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {cs, rs, ls, n, m};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        expected_q.push_back(predict_omega(m, n, ls, rs, cs, last));
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain_and_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_epsilon(logic [15:0] value);
        drain_and_idle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        eps_reg = value;
    endtask

    task automatic send_random_split(logic last);
        logic [7:0]  m;
        logic [7:0]  n;
        logic [31:0] cs;
        logic [24:0] sr;
        m = 8'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(2, 40));
        n = 8'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(2, 40));
        case ($urandom_range(0, 3))
            0: cs = $urandom;
            1: cs = $urandom_range(0, 32'h00FFFFFF);
            default: cs = 32'($urandom_range(0, 32'h01FFFFFF));
        endcase
        sr = ($urandom_range(0, 9) == 0) ? '0 : 25'($urandom);
        send_split(m, n, ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom),
                   24'($urandom), sr[24] ? cs : 32'($urandom_range(0, 32'h0FFFFFFF)), last);
    endtask

    task automatic test_directed();
        send_split(8'd2, 8'd2, 24'h010000, 24'h010000, 32'h00050000, 1'b0);
        send_split(8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_split(8'd0, 8'd0, 24'h0, 24'h0, 32'h0, 1'b0);
        send_split(8'd1, 8'd1, 24'h1000, 24'h1000, 32'h10000, 1'b0);
        send_split(8'd0, 8'd5, 24'h1000, 24'h1000, 32'h10000, 1'b0);
        send_split(8'd3, 8'd4, 24'h0, 24'h0, 32'h12345678, 1'b1);
        send_split(8'd2, 8'd2, 24'hFFFFFF, 24'hFFFFFF, 32'h0, 1'b0);
        send_split(8'd2, 8'd2, 24'hFFFFFF, 24'h0, 32'h0, 1'b0);
        send_split(8'd2, 8'd2, 24'h000001, 24'h0, 32'h0, 1'b0);
        send_split(8'd255, 8'd2, 24'h000100, 24'h000100, 32'h0, 1'b1);
        // exact zero denominator at epsilon 655: c - s + 655*4 = 0
        send_split(8'd2, 8'd2, 24'h000A3C, 24'h000000, 32'h00000000, 1'b0);
        send_split(8'd2, 8'd2, 24'h000001, 24'h000001, 32'hFFFFFFFF, 1'b1);
    endtask

    task automatic test_epsilon_settings();
        logic [15:0] eps_list[3] = '{16'd0, 16'hFFFF, 16'd1};
        foreach (eps_list[k])
        begin
            write_epsilon(eps_list[k]);
            send_split(8'd2, 8'd2, 24'h001000, 24'h001000, 32'h002000, 1'b0);
            send_split(8'd7, 8'd9, 24'hABCDEF, 24'h123456, 32'h00800000, 1'b0);
            repeat (20) send_random_split($urandom_range(0, 4) == 0);
            send_split(8'd2, 8'd3, 24'h0, 24'h0, 32'h0, 1'b1);
        end
    endtask

    task automatic test_random_vectors();
        for (int k = 0; k < 700; k++)
        begin
            if (k == 350)
                write_epsilon(16'($urandom));
            if (k == 600)
            begin
                write_epsilon(16'd655);
                quiet = 1'b1;
            end
            send_random_split($urandom_range(0, 7) == 0 || k == 699);
        end
    endtask

    initial
    begin : result_checker
        omega_res_t exp_r;
        int         gap;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.sat)
                        sat_seen++;
                    if (exp_r.omega[31])
                        neg_seen++;
                    if (m_axis_tdata[31:0] !== exp_r.omega
                        || m_axis_tdata[62:32] !== exp_r.run_max
                        || m_axis_tdata[63] !== exp_r.sat
                        || m_axis_tlast !== exp_r.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp omega %h max %h sat %b last %b, got %h %h %b %b",
                                     exp_r.omega, exp_r.run_max, exp_r.sat, exp_r.last,
                                     m_axis_tdata[31:0], m_axis_tdata[62:32],
                                     m_axis_tdata[63], m_axis_tlast);
                    end
                end
            end
            if (!quiet && m_axis_tready && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("omega_statistic_max_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_epsilon_settings();
        test_random_vectors();
        drain_and_idle();
        $display("checked %0d results, %0d saturated, %0d negative, epsilon at 0, 1, max",
                 results_seen, sat_seen, neg_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("omega_statistic_max_top_test OK");
        else
            $display("omega_statistic_max_top_test NOT OK");
        $finish;
    end
endmodule
